### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while rst is high.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Signal must hold its value in the cycle after cond.
`define CHK_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((cond) |=> $stable(sig))) \
    else $error(msg);

`endif

### hw/rtl/rle24b64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rle24b64_pkg;

  localparam logic [7:0] RUN_MAX    = 8'd255;
  localparam logic [7:0] MIN_WRAP   = 8'd12;
  localparam logic [7:0] WRAP_RESET = 8'd76;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;

  // One queued job: one or two 4-byte records {count, red, green, blue}.
  typedef struct packed {
    logic        two;   // rec1 follows rec0
    logic        last;  // item closes the frame
    logic [31:0] rec0;
    logic [31:0] rec1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } qslot_t;

  // Base64 alphabet.
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    priority if (v < 6'd26) begin
      return 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      return 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rle24b64_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rle24b64_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          pixel_value,
  input  wire logic                 frame_last,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 q_full,
  output rle24b64_pkg::qslot_t      push
);

  logic [23:0] run_pixel, run_pixel_next;
  logic [7:0]  run_length, run_length_next;
  logic        run_open, run_open_next;

  logic [23:0] px;
  logic        accept;
  logic        has_a;
  logic [23:0] pix_cont;
  logic [7:0]  len_cont;

  assign in_stall = q_full;

  always_comb begin
    px       = pixel_value[23:0];
    accept   = in_valid && !q_full;
    has_a    = 1'b0;
    pix_cont = run_pixel;
    len_cont = run_length;

    priority if (!run_open) begin
      pix_cont = px;
      len_cont = 8'd1;
    end else if (px == run_pixel && run_length < rle24b64_pkg::RUN_MAX) begin
      len_cont = run_length + 8'd1;
    end else begin
      // run closes: emit it and start a new one
      has_a    = 1'b1;
      pix_cont = px;
      len_cont = 8'd1;
    end

    push.valid     = accept && (has_a || frame_last);
    push.data.two  = has_a && frame_last;
    push.data.last = frame_last;
    push.data.rec0 = has_a ? {run_length, run_pixel} : {len_cont, pix_cont};
    push.data.rec1 = {len_cont, pix_cont};

    if (frame_last) begin
      run_pixel_next  = '0;
      run_length_next = '0;
      run_open_next   = 1'b0;
    end else begin
      run_pixel_next  = pix_cont;
      run_length_next = len_cont;
      run_open_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pixel  <= '0;
      run_length <= '0;
      run_open   <= 1'b0;
    end else if (accept) begin
      run_pixel  <= run_pixel_next;
      run_length <= run_length_next;
      run_open   <= run_open_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rle24b64_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rle24b64_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rle24b64_pkg::qslot_t push,
  output logic                      full,
  input  wire logic                 pop,
  output rle24b64_pkg::qslot_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  rle24b64_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full      = (count == CNT_FULL);
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rle24b64_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rle24b64_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           wrap_column,
  input  wire rle24b64_pkg::qslot_t head,
  output logic                      pop,
  output logic [7:0]                out_char,
  output logic                      item_done,
  output logic                      frame_done,
  output logic                      out_valid,
  input  wire logic                 out_stall
);

  typedef enum logic [1:0] {ST_PACK, ST_CHAR, ST_NL, ST_PAD} state_t;

  state_t      state, state_next;
  logic [1:0]  k, k_next;
  logic [23:0] grp, grp_next;
  logic [3:0]  bi, bi_next;
  logic [1:0]  pcnt, pcnt_next;
  logic [7:0]  p0, p0_next, p1, p1_next;
  logic [7:0]  col, col_next;
  logic [7:0]  out_char_next;
  logic        item_done_next, frame_done_next, out_valid_next;

  logic [7:0]  byte_at [8];
  logic [2:0]  i0, i1, i2;
  logic [7:0]  b0, b1, b2;
  logic [23:0] tri_word;
  logic [3:0]  tri_bi;
  logic [3:0]  nb, rem;
  logic [7:0]  lim;
  logic [8:0]  col_sum;
  logic        adv, gend;

  always_comb begin
    byte_at[0] = head.data.rec0[31:24];
    byte_at[1] = head.data.rec0[23:16];
    byte_at[2] = head.data.rec0[15:8];
    byte_at[3] = head.data.rec0[7:0];
    byte_at[4] = head.data.rec1[31:24];
    byte_at[5] = head.data.rec1[23:16];
    byte_at[6] = head.data.rec1[15:8];
    byte_at[7] = head.data.rec1[7:0];
  end

  assign i0 = bi[2:0];
  assign i1 = bi[2:0] + 3'd1;
  assign i2 = bi[2:0] + 3'd2;
  assign b0 = byte_at[i0];
  assign b1 = byte_at[i1];
  assign b2 = byte_at[i2];

  assign nb      = head.data.two ? 4'd8 : 4'd4;
  assign rem     = nb - bi;
  assign lim     = (wrap_column < rle24b64_pkg::MIN_WRAP) ? rle24b64_pkg::MIN_WRAP
                                                          : wrap_column;
  assign col_sum = {1'b0, col} + 9'd4;
  assign adv     = !out_valid || !out_stall;

  // Complete a triple from the pending bytes plus the next entry bytes.
  always_comb begin
    unique case (pcnt)
      2'd1: begin
        tri_word = {p0, b0, b1};
        tri_bi   = bi + 4'd2;
      end
      2'd2: begin
        tri_word = {p0, p1, b0};
        tri_bi   = bi + 4'd1;
      end
      default: begin
        tri_word = {b0, b1, b2};
        tri_bi   = bi + 4'd3;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    k_next          = k;
    grp_next        = grp;
    bi_next         = bi;
    pcnt_next       = pcnt;
    p0_next         = p0;
    p1_next         = p1;
    col_next        = col;
    out_char_next   = out_char;
    item_done_next  = item_done;
    frame_done_next = frame_done;
    out_valid_next  = out_valid;
    pop             = 1'b0;
    gend            = 1'b0;

    if (adv) begin
      out_valid_next  = 1'b1;
      item_done_next  = 1'b0;
      frame_done_next = 1'b0;

      unique case (state)
        ST_PACK: begin
          out_valid_next = head.valid;
          out_char_next  = rle24b64_pkg::b64_sym(tri_word[23:18]);
          if (head.valid) begin
            grp_next   = tri_word;
            bi_next    = tri_bi;
            pcnt_next  = 2'd0;
            k_next     = 2'd1;
            state_next = ST_CHAR;
          end
        end
        ST_CHAR: begin
          unique case (k)
            2'd1: begin
              out_char_next = rle24b64_pkg::b64_sym(grp[17:12]);
              k_next        = 2'd2;
            end
            2'd2: begin
              out_char_next = rle24b64_pkg::b64_sym(grp[11:6]);
              k_next        = 2'd3;
            end
            default: begin
              out_char_next = rle24b64_pkg::b64_sym(grp[5:0]);
              if (col_sum >= {1'b0, lim}) begin
                col_next   = '0;
                state_next = ST_NL;
              end else begin
                col_next = col_sum[7:0];
                gend     = 1'b1;
              end
            end
          endcase
        end
        ST_NL: begin
          out_char_next = rle24b64_pkg::NEWLINE;
          gend          = 1'b1;
        end
        ST_PAD: begin
          unique case (k)
            2'd0: begin
              out_char_next = rle24b64_pkg::b64_sym(p0[7:2]);
              k_next        = 2'd1;
            end
            2'd1: begin
              out_char_next = rle24b64_pkg::b64_sym(
                                {p0[1:0], (pcnt == 2'd2) ? p1[7:4] : 4'h0});
              k_next        = 2'd2;
            end
            2'd2: begin
              out_char_next = (pcnt == 2'd2) ? rle24b64_pkg::b64_sym({p1[3:0], 2'b00})
                                             : rle24b64_pkg::PAD_CHAR;
              k_next        = 2'd3;
            end
            default: begin
              // last character of the frame; state returns to reset
              out_char_next   = rle24b64_pkg::PAD_CHAR;
              item_done_next  = 1'b1;
              frame_done_next = 1'b1;
              pop             = 1'b1;
              pcnt_next       = 2'd0;
              col_next        = '0;
              bi_next         = '0;
              k_next          = 2'd0;
              state_next      = ST_PACK;
            end
          endcase
        end
        default: state_next = ST_PACK;
      endcase

      // After a full group (and its newline, if any).
      if (gend) begin
        priority if (rem >= 4'd3) begin
          state_next = ST_PACK;
        end else if (head.data.last && rem != 4'd0) begin
          p0_next    = b0;
          p1_next    = b1;
          pcnt_next  = rem[1:0];
          k_next     = 2'd0;
          state_next = ST_PAD;
        end else begin
          item_done_next  = 1'b1;
          frame_done_next = head.data.last;
          pop             = 1'b1;
          bi_next         = '0;
          state_next      = ST_PACK;
          if (head.data.last) begin
            pcnt_next = 2'd0;
            col_next  = '0;
          end else begin
            p0_next   = b0;
            p1_next   = b1;
            pcnt_next = rem[1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PACK;
      k          <= 2'd0;
      bi         <= '0;
      pcnt       <= 2'd0;
      col        <= '0;
      out_valid  <= 1'b0;
      item_done  <= 1'b0;
      frame_done <= 1'b0;
    end else begin
      state      <= state_next;
      k          <= k_next;
      bi         <= bi_next;
      pcnt       <= pcnt_next;
      col        <= col_next;
      out_valid  <= out_valid_next;
      item_done  <= item_done_next;
      frame_done <= frame_done_next;
    end
    grp      <= grp_next;
    p0       <= p0_next;
    p1       <= p1_next;
    out_char <= out_char_next;
  end

endmodule

`default_nettype wire

### hw/rtl/rle24_base64_pixel_encoder_unit.sv
// Run-length pixel encoder with base64 text output.
// Input channel: pixel_value (low 24 bits used) and frame_last, with in_valid /
//   in_stall. Output channel: out_char, item_done, frame_done, with out_valid /
//   out_stall. Both move an item at a clock edge with valid high, stall low.
// cfg_wr_en / cfg_wr_data write wrap_column (reset 76); write only while idle.
// An item that only extends or starts a run yields no characters. Every other
// item is queued as one or two 4-byte records and turned into characters at one
// character per cycle, while out_stall is low, by the back end; the first
// character of an item is registered on the edge after it reaches the queue
// head, when the output is not stalled (an empty queue puts an accepted item at
// its head straight away). An item that closes one run yields 4 or 8
// characters, depending on how many bytes wait for a full triple (5.33 on
// average), plus any newline; the last item of a frame yields up to 17. The
// output character rate sets the sustained rate; the queue of QUEUE_DEPTH
// items lets the input side keep accepting pixels while characters drain.
// A stalled output holds its character; the back end waits, the queue fills
// and then in_stall rises. Synchronous rst clears runs, the queue, the column
// and sets wrap_column to 76; the column and pending bytes clear after the last
// character of a frame, and the runs when its frame_last item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module rle24_base64_pixel_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic [31:0] pixel_value,
  input  wire logic        frame_last,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic [7:0]       out_char,
  output logic             item_done,
  output logic             frame_done,
  output logic             out_valid,
  input  wire logic        out_stall
);

  logic [7:0]           wrap_column;
  rle24b64_pkg::qslot_t q_push;
  rle24b64_pkg::qslot_t q_head;
  logic                 q_full;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_column <= rle24b64_pkg::WRAP_RESET;
    end else if (cfg_wr_en) begin
      wrap_column <= cfg_wr_data;
    end
  end

  rle24b64_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_value (pixel_value),
    .frame_last  (frame_last),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .push        (q_push)
  );

  rle24b64_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head)
  );

  rle24b64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wrap_column (wrap_column),
    .head        (q_head),
    .pop         (q_pop),
    .out_char    (out_char),
    .item_done   (item_done),
    .frame_done  (frame_done),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire

### hw/rtl/rle24b64_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rle24b64_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] out_char,
  input wire logic       item_done,
  input wire logic       frame_done,
  input wire logic       out_valid,
  input wire logic       out_stall
);

  logic out_held;
  logic pad_item_end;
  logic nl_fire;
  logic nl_shown;

  assign out_held     = out_valid && out_stall;
  assign pad_item_end = out_valid && item_done && (out_char == rle24b64_pkg::PAD_CHAR);
  assign nl_shown     = out_valid && (out_char == rle24b64_pkg::NEWLINE);
  assign nl_fire      = nl_shown && !out_stall;

  `CHK_ASSERT(a_valid_holds, out_held |=> out_valid, "out_valid dropped under stall")
  `CHK_HOLD(a_char_holds, out_held, out_char, "out_char changed under stall")
  `CHK_ASSERT(a_frame_ends_item, out_valid && frame_done |-> item_done, "frame_done alone")
  `CHK_ASSERT(a_pad_at_end, pad_item_end |-> frame_done, "padding ends an item, not the frame")
  `CHK_ASSERT(a_no_double_nl, nl_fire |=> !nl_shown, "two newlines in a row")

endmodule

bind rle24_base64_pixel_encoder_unit rle24b64_checker u_checker (.*);

`default_nettype wire
